>>> hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;

    localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    typedef logic [ADDR_W-1:0] t_addr;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [7:0]  CODE_NEWLINE = 8'd10;
    localparam logic [7:0]  CODE_RETURN  = 8'd13;
    localparam logic [7:0]  ATTR_BYTE    = 8'h07;
    localparam logic [15:0] BLANK_CELL   = 16'h0720;

    typedef struct packed {
        logic        we;
        logic        re;
        t_addr       addr;
        logic [15:0] wdata;
    } t_ram_req;

endpackage

>>> hw/rtl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console engine: cursor, put character, scroll, clear and cell read
// over a ring-addressed screen store.
// ----------------------------------------------------------------------------
// Return, newline, an out-of-range read or the unused selector go from
// execute to done; a printable put passes the put state, a read the read and
// read-wait states; a scroll adds a pass over the bottom row's COLUMNS cells,
// clear a pass over all CELL_COUNT cells. One item at a time: the next
// transfer is taken once the result is loaded. Reset: synchronous, active low;
// then a clearing pass writes blanks to all CELL_COUNT cells, stall held high.
// ----------------------------------------------------------------------------
module text_console_writer_unit import tcw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_cell_value,
    output logic [10:0] o_cursor_pos,
    output logic        o_scrolled
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_EXEC   = 4'd2;
    localparam logic [3:0] S_PUT    = 4'd3;
    localparam logic [3:0] S_SCROLL = 4'd4;
    localparam logic [3:0] S_CLEAR  = 4'd5;
    localparam logic [3:0] S_READ   = 4'd6;
    localparam logic [3:0] S_RWAIT  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]       r_state, n_state;
    t_addr            r_cnt, n_cnt;
    t_addr            r_base, n_base;
    t_addr            r_lin, n_lin;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [1:0]       r_func, n_func;
    logic [7:0]       r_char, n_char;
    logic [10:0]      r_idx, n_idx;
    logic [15:0]      r_value, n_value;
    logic             r_scr, n_scr;
    logic             r_out_valid, n_out_valid;
    logic [15:0]      r_out_value, n_out_value;
    logic [10:0]      r_out_pos, n_out_pos;
    logic             r_out_scr, n_out_scr;

    t_addr       log_addr;
    t_addr       phys_addr;
    t_ram_req    ram_req;
    logic [15:0] ram_rdata;
    logic        idx_oor;
    logic        out_free;

    tcw_addr_map u_addr (
        .i_logical  (log_addr),
        .i_base     (r_base),
        .o_physical (phys_addr)
    );

    tcw_screen_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        priority if (r_state == S_PUT) begin
            log_addr = r_lin;
        end else if (r_state == S_READ) begin
            log_addr = ADDR_W'(r_idx);
        end else begin
            log_addr = r_cnt;
        end
    end

    always_comb begin
        ram_req.addr  = phys_addr;
        ram_req.we    = (r_state == S_INIT) || (r_state == S_CLEAR) ||
                        (r_state == S_SCROLL) || (r_state == S_PUT);
        ram_req.re    = (r_state == S_READ);
        ram_req.wdata = (r_state == S_PUT) ? {ATTR_BYTE, r_char} : BLANK_CELL;
    end

    assign idx_oor  = ({5'b0, r_idx} >= 16'(CELL_COUNT));
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_base      = r_base;
        n_lin       = r_lin;
        n_row       = r_row;
        n_col       = r_col;
        n_func      = r_func;
        n_char      = r_char;
        n_idx       = r_idx;
        n_value     = r_value;
        n_scr       = r_scr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_value = r_out_value;
        n_out_pos   = r_out_pos;
        n_out_scr   = r_out_scr;

        unique case (r_state)
            S_INIT: begin
                n_cnt = r_cnt + t_addr'(1);
                if (r_cnt == ADDR_W'(CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_func;
                    n_char  = i_char_code;
                    n_idx   = i_cell_index;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_value = 16'd0;
                n_scr   = 1'b0;
                n_cnt   = '0;
                n_state = S_DONE;
                unique case (r_func)
                    FUNC_PUT: begin
                        priority if (r_char == CODE_NEWLINE) begin
                            n_col = '0;
                            if (r_row == ROW_W'(ROWS - 1)) begin
                                n_lin   = ADDR_W'(LAST_BASE);
                                n_scr   = 1'b1;
                                n_state = S_SCROLL;
                            end else begin
                                n_row = r_row + ROW_W'(1);
                                n_lin = r_lin - t_addr'(r_col) + t_addr'(COLUMNS);
                            end
                        end else if (r_char == CODE_RETURN) begin
                            n_col = '0;
                            n_lin = r_lin - t_addr'(r_col);
                        end else begin
                            n_state = S_PUT;
                        end
                    end
                    FUNC_CLEAR: begin
                        n_state = S_CLEAR;
                    end
                    FUNC_READ: begin
                        if (!idx_oor) begin
                            n_state = S_READ;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_PUT: begin
                n_state = S_DONE;
                if (r_col == COL_W'(COLUMNS - 1)) begin
                    n_col = '0;
                    if (r_row == ROW_W'(ROWS - 1)) begin
                        n_lin   = ADDR_W'(LAST_BASE);
                        n_scr   = 1'b1;
                        n_state = S_SCROLL;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                        n_lin = r_lin + t_addr'(1);
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                    n_lin = r_lin + t_addr'(1);
                end
            end
            S_SCROLL: begin
                n_cnt = r_cnt + t_addr'(1);
                if (r_cnt == ADDR_W'(COLUMNS - 1)) begin
                    n_base  = (r_base == ADDR_W'(CELL_COUNT - COLUMNS)) ? '0
                            : r_base + ADDR_W'(COLUMNS);
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                n_cnt = r_cnt + t_addr'(1);
                if (r_cnt == ADDR_W'(CELL_COUNT - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_state = S_RWAIT;
            end
            S_RWAIT: begin
                n_value = ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_value;
                    n_out_pos   = 11'(r_lin);
                    n_out_scr   = r_scr;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_base      <= '0;
            r_lin       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_base      <= n_base;
            r_lin       <= n_lin;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_char      <= n_char;
        r_idx       <= n_idx;
        r_value     <= n_value;
        r_scr       <= n_scr;
        r_out_value <= n_out_value;
        r_out_pos   <= n_out_pos;
        r_out_scr   <= n_out_scr;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_out_value;
    assign o_cursor_pos = r_out_pos;
    assign o_scrolled   = r_out_scr;

endmodule

>>> hw/rtl/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one port, write or registered read each cycle.
// ----------------------------------------------------------------------------
module tcw_screen_ram import tcw_pkg::*; (
    input  logic        i_clk,
    input  t_ram_req    i_req,
    output logic [15:0] o_rdata
);

    logic [15:0] r_mem [CELL_COUNT];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/tcw_addr_map.sv
// ----------------------------------------------------------------------------
// tcw_addr_map
// Shared address unit: logical cell index plus ring row base, modulo the
// cell count.
// ----------------------------------------------------------------------------
module tcw_addr_map import tcw_pkg::*; (
    input  t_addr i_logical,
    input  t_addr i_base,
    output t_addr o_physical
);

    localparam logic [ADDR_W:0] COUNT_EXT = (ADDR_W+1)'(CELL_COUNT);

    logic [ADDR_W:0] sum;
    logic [ADDR_W:0] wrapped;

    always_comb begin
        sum     = {1'b0, i_logical} + {1'b0, i_base};
        wrapped = (sum >= COUNT_EXT) ? (sum - COUNT_EXT) : sum;
    end

    assign o_physical = wrapped[ADDR_W-1:0];

endmodule

>>> hw/rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_func,
    input logic [7:0]  i_char_code,
    input logic [10:0] i_cell_index,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_cell_value,
    input logic [10:0] o_cursor_pos,
    input logic        o_scrolled
);

    // held result during a stalled transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cell_value)
            && $stable(o_cursor_pos) && $stable(o_scrolled))
        else $error("result changed while stalled");

    // reset empties the output and starts the clearing pass
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("reset state wrong");

    // a scroll always leaves the cursor at the start of the bottom row
    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scrolled |-> o_cursor_pos == 11'(LAST_BASE))
        else $error("cursor wrong after scroll");

    // only a put scrolls, and a put returns no cell
    a_scroll_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scrolled |-> o_cell_value == 16'd0)
        else $error("cell value on a scrolling step");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> {5'b0, o_cursor_pos} < 16'(CELL_COUNT))
        else $error("cursor outside the screen");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (.*);

>>> bench/tb_text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// tb_text_console_writer_unit
// Self-checking bench for the text console writer. Commands go in through
// the valid/stall input channel; a scoreboard keeps its own screen and cursor,
// predicts the status of every command and compares each returned transfer
// field by field. A short directed prelude covers the corner bytes and
// selectors; random text lines, cell reads and noise follow, with random
// idling on both channels.
// ----------------------------------------------------------------------------
module tb_text_console_writer_unit;
    import tcw_pkg::*;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int         ITEM_GOAL  = 1850;

    typedef struct {
        logic [15:0] cell_value;
        logic [10:0] cursor_pos;
        logic        scrolled;
    } console_status_t;

    class console_scoreboard;
        logic [15:0]     cells [CELL_COUNT];
        int unsigned     cursor;
        console_status_t owed_status [$];
        int unsigned     errors;

        function new();
            wipe_screen();
            cursor = 0;
            errors = 0;
        endfunction

        function void wipe_screen();
            for (int k = 0; k < CELL_COUNT; k++) cells[k] = BLANK_CELL;
        endfunction

        function bit scroll_up();
            if (cursor / COLUMNS < ROWS) return 1'b0;
            for (int k = 0; k < LAST_BASE; k++) cells[k] = cells[k + COLUMNS];
            for (int k = LAST_BASE; k < CELL_COUNT; k++) cells[k] = BLANK_CELL;
            cursor -= COLUMNS;
            return 1'b1;
        endfunction

        function void note_command(logic [1:0] func, logic [7:0] code, logic [10:0] index);
            console_status_t st;
            int unsigned     row;
            st  = '{16'h0000, 11'h000, 1'b0};
            row = cursor / COLUMNS;
            case (func)
                FUNC_PUT: begin
                    if (code == CODE_NEWLINE) begin
                        cursor      = (row + 1) * COLUMNS;
                        st.scrolled = scroll_up();
                    end else if (code == CODE_RETURN) begin
                        cursor = row * COLUMNS;
                    end else begin
                        if (cursor < CELL_COUNT) cells[cursor] = {ATTR_BYTE, code};
                        cursor++;
                        st.scrolled = scroll_up();
                    end
                end
                FUNC_CLEAR: wipe_screen();
                FUNC_READ: begin
                    if (index < CELL_COUNT) st.cell_value = cells[index];
                end
                default: ;
            endcase
            st.cursor_pos = 11'(cursor);
            owed_status.push_back(st);
        endfunction

        function void check_status(logic [15:0] value, logic [10:0] pos, logic scrolled);
            console_status_t want;
            if (owed_status.size() == 0) begin
                $error("unexpected result transfer: cell_value %h cursor_pos %0d scrolled %b",
                       value, pos, scrolled);
                errors++;
                return;
            end
            want = owed_status.pop_front();
            if (value !== want.cell_value) begin
                $error("cell_value: expected %h, actual %h", want.cell_value, value);
                errors++;
            end
            if (pos !== want.cursor_pos) begin
                $error("cursor_pos: expected %0d, actual %0d", want.cursor_pos, pos);
                errors++;
            end
            if (scrolled !== want.scrolled) begin
                $error("scrolled: expected %b, actual %b", want.scrolled, scrolled);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_func       = FUNC_PUT;
    logic [7:0]  i_char_code  = 8'h00;
    logic [10:0] i_cell_index = 11'h000;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [15:0] o_cell_value;
    logic [10:0] o_cursor_pos;
    logic        o_scrolled;

    console_scoreboard sb = new();

    bit          in_idle_on  = 1'b0;
    bit          out_idle_on = 1'b0;
    int unsigned out_hold    = 0;
    int unsigned sent        = 0;

    text_console_writer_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_value (o_cell_value),
        .o_cursor_pos (o_cursor_pos),
        .o_scrolled   (o_scrolled)
    );

    always #10 i_clk = ~i_clk;

    // mostly short, occasionally long
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (out_hold != 0) begin
            out_hold <= out_hold - 1;
        end else if (!out_idle_on) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 1) == 1);
            out_hold    <= idle_length();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_status(o_cell_value, o_cursor_pos, o_scrolled);
        end
    end

    task automatic send_command(input logic [1:0] func, input logic [7:0] code,
                                input logic [10:0] index);
        int unsigned gap;
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_char_code  <= code;
        i_cell_index <= index;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_command(func, code, index);
        sent++;
        gap = in_idle_on ? idle_length() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (sb.owed_status.size() != 0) @(posedge i_clk);
    endtask

    // reads favour cells just behind the cursor, where text has landed
    function automatic logic [10:0] pick_read_index();
        int unsigned r;
        int unsigned back;
        r    = $urandom_range(0, 9);
        back = $urandom_range(0, 2 * COLUMNS);
        if (r < 7) begin
            if (sb.cursor >= back) return 11'(sb.cursor - back);
            return 11'($urandom_range(0, CELL_COUNT - 1));
        end
        if (r < 9) return 11'($urandom_range(0, CELL_COUNT - 1));
        return 11'($urandom_range(CELL_COUNT, 2047));
    endfunction

    initial begin
        int unsigned kind;
        int unsigned len;
        logic [1:0]  f;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed prelude
        send_command(FUNC_READ, 8'h00, 11'd0);
        send_command(FUNC_READ, 8'hFF, 11'(CELL_COUNT - 1));
        send_command(FUNC_READ, 8'h00, 11'h7FF);
        send_command(FUNC_READ, 8'h00, 11'(CELL_COUNT));
        send_command(FUNC_PUT, 8'h41, 11'h000);
        send_command(FUNC_PUT, 8'h00, 11'h7FF);
        send_command(FUNC_PUT, 8'hFF, 11'h000);
        send_command(FUNC_PUT, 8'h80, 11'h000);
        send_command(FUNC_PUT, 8'h7F, 11'h000);
        for (int k = 0; k < 5; k++) send_command(FUNC_READ, 8'h00, 11'(k));
        send_command(FUNC_PUT, CODE_RETURN, 11'h000);
        send_command(FUNC_PUT, CODE_NEWLINE, 11'h000);
        send_command(FUNC_SPARE, 8'hFF, 11'h7FF);
        send_command(FUNC_CLEAR, 8'h55, 11'h2AA);
        send_command(FUNC_READ, 8'h00, 11'd0);

        // phase 0 no idling, 1 both sides, 2 sender only, 3 receiver only
        for (int phase = 0; phase < 4; phase++) begin
            in_idle_on  = (phase == 1) || (phase == 2);
            out_idle_on = (phase == 1) || (phase == 3);
            while (sent < (phase + 1) * (ITEM_GOAL / 4)) begin
                kind = $urandom_range(0, 99);
                if (kind < 55) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 170)
                                                      : $urandom_range(0, 30);
                    repeat (len) send_command(FUNC_PUT, 8'($urandom), 11'($urandom));
                    send_command(FUNC_PUT,
                                 ($urandom_range(0, 3) == 0) ? CODE_RETURN : CODE_NEWLINE,
                                 11'($urandom));
                end else if (kind < 85) begin
                    repeat ($urandom_range(1, 6))
                        send_command(FUNC_READ, 8'($urandom), pick_read_index());
                end else if (kind < 97) begin
                    repeat ($urandom_range(1, 4)) begin
                        f = 2'($urandom);
                        if (f == FUNC_CLEAR) f = FUNC_SPARE;
                        send_command(f, 8'($urandom), 11'($urandom));
                    end
                end else begin
                    send_command(FUNC_CLEAR, 8'($urandom), 11'($urandom));
                end
            end
            i_in_valid <= 1'b0;
            wait_drained();
            @(posedge i_clk);
        end

        wait_drained();
        repeat (CELL_COUNT + 2) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_status.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
